/* src/iaps_pkg.sv */
// Shared types, constants and helpers for the isochronous audio packet-size sequencer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package iaps_pkg;

    // Field and register widths
    localparam int unsigned RATE_W     = 20;
    localparam int unsigned FBYTES_W   = 7;
    localparam int unsigned IVAL_W     = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned FB_W       = 32;
    localparam int unsigned EPMAX_W    = 16;
    localparam int unsigned PBYTES_W   = 20;
    localparam int unsigned PFRAMES_W  = 14;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned XCNT_W     = 9;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Datapath widths
    localparam int unsigned ACC_W  = 48;              // frame accumulator and quotient
    localparam int unsigned DIV_W  = 17;              // divisor, up to 65536
    localparam int unsigned IPS_W  = 13;              // packets per second, up to 8000
    localparam int unsigned QMS_W  = 9;               // queue target in ms
    localparam int unsigned CEIL_W = 21;              // nominal frames per packet
    localparam int unsigned NOMB_W = CEIL_W + FBYTES_W;

    // Defaults for the top-level parameters
    localparam int unsigned PACKETS_PER_TRANSFER_DEF = 16;
    localparam int unsigned MAX_TRANSFERS_DEF        = 256;

    // Scheduling constants
    localparam int unsigned IPS_HS        = 8000;
    localparam int unsigned IPS_FS        = 1000;
    localparam int unsigned IVAL_SHIFT_MAX = 12;
    localparam int unsigned IVAL_FS_ABOVE = 16;
    localparam int unsigned QMS_IMPLICIT  = 320;
    localparam int unsigned QMS_EXPLICIT  = 180;
    localparam int unsigned MS_PER_S      = 1000;
    localparam int unsigned MIN_TRANSFERS = 24;
    localparam int unsigned FB_ONE        = 65536;    // 1.0 in 16.16

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE   = 3'd0,
        CFG_FRAME_BYTES   = 3'd1,
        CFG_EP_INTERVAL   = 3'd2,
        CFG_ADJUST_MODE   = 3'd3,
        CFG_FEEDBACK      = 3'd4,
        CFG_EP_MAX_BYTES  = 3'd5,
        CFG_EXPLICIT_FB   = 3'd6
    } t_cfg_idx;

    // Adjust modes
    localparam logic [MODE_W-1:0] MODE_NOMINAL      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONSERVATIVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FEEDBACK     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CFG_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVER_MAX = 2'd2;

    // Register reset values
    localparam logic [RATE_W-1:0]   RST_SAMPLE_RATE = 20'd48000;
    localparam logic [FBYTES_W-1:0] RST_FRAME_BYTES = 7'd4;
    localparam logic [IVAL_W-1:0]   RST_EP_INTERVAL = 8'd1;
    localparam logic [MODE_W-1:0]   RST_ADJUST_MODE = MODE_CONSERVATIVE;

    // Saturation limits of the result fields
    localparam logic [PBYTES_W-1:0]  PBYTES_MAX  = '1;
    localparam logic [PFRAMES_W-1:0] PFRAMES_MAX = '1;

    // Packets per second from the high-speed interval exponent
    function automatic logic [IPS_W-1:0] packets_per_second(input logic [IVAL_W-1:0] iv);
        logic [IVAL_W-1:0] sh;
        logic [IPS_W-1:0]  v;
        sh = iv - IVAL_W'(1);
        if (sh > IVAL_W'(IVAL_SHIFT_MAX)) begin
            sh = IVAL_W'(IVAL_SHIFT_MAX);
        end
        v = IPS_W'(IPS_HS) >> sh[3:0];
        if (iv <= IVAL_W'(1)) begin
            v = IPS_W'(IPS_HS);
        end else if (iv > IVAL_W'(IVAL_FS_ABOVE)) begin
            v = IPS_W'(IPS_FS);
        end else if (v == '0) begin
            v = IPS_W'(1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/iso_audio_packet_size_sequencer.sv */
// Isochronous audio OUT packet-size sequencer, top level.
// Depends on iaps_pkg; the checker in iaps_checker.sv binds to it.
//
// One item per packet slot; each item yields one result giving the packet's frame and byte
// count, its place in the transfer, a status and the transfer-pool size. All ratio divisions
// go through a single radix-2 restoring divider that retires one quotient bit per cycle over a
// 48-bit dividend; the transfer-pool count uses a multiply by a constant reciprocal. After
// reset and after every write to a defined register the block refreshes its cached ratios (one
// divider pass plus two multiplies) with o_stall high. A conservative or feedback item passes
// the divider, the frame step, the byte multiply and the status step before its result is
// valid; nominal mode and invalid configurations skip the divider and the frame step. The next
// item can be taken in the cycle after the result has been taken, unless a write awaits refresh.
`default_nettype none

module iso_audio_packet_size_sequencer #(
    parameter int unsigned PACKETS_PER_TRANSFER = iaps_pkg::PACKETS_PER_TRANSFER_DEF,
    parameter int unsigned MAX_TRANSFERS        = iaps_pkg::MAX_TRANSFERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_restart,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [iaps_pkg::PBYTES_W-1:0]       o_packet_bytes,
    output logic [iaps_pkg::PFRAMES_W-1:0]      o_packet_frames,
    output logic                                o_last_in_transfer,
    output logic [iaps_pkg::STATUS_W-1:0]       o_status,
    output logic [iaps_pkg::XCNT_W-1:0]         o_transfer_count,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [iaps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [iaps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned ACC_W    = iaps_pkg::ACC_W;
    localparam int unsigned DIV_W    = iaps_pkg::DIV_W;
    localparam int unsigned BYTES_W  = ACC_W + iaps_pkg::FBYTES_W;
    localparam int unsigned POS_W    = (PACKETS_PER_TRANSFER > 1) ?
                                       $clog2(PACKETS_PER_TRANSFER) : 1;
    localparam int unsigned XC_W     = $clog2(MAX_TRANSFERS + 1);
    localparam int unsigned CNT_W    = $clog2(ACC_W);
    localparam int unsigned XFER_DEN = iaps_pkg::MS_PER_S * PACKETS_PER_TRANSFER;
    localparam int unsigned PROD_W   = iaps_pkg::IPS_W + iaps_pkg::QMS_W;
    // transfer count: floor(n / XFER_DEN) as (n * ceil(2^(XN_W+XD_L) / XFER_DEN)) >> (XN_W+XD_L),
    // exact for every n below 2^XN_W
    localparam int unsigned XN_W     = PROD_W + 1;
    localparam int unsigned XD_L     = $clog2(XFER_DEN);
    localparam int unsigned XM_W     = XN_W + 1;
    localparam int unsigned XMUL_W   = XN_W + XM_W;
    localparam int unsigned XQ_W     = XMUL_W - (XN_W + XD_L);
    localparam longint unsigned XFER_RECIP =
        ((64'd1 << (XN_W + XD_L)) + 64'(XFER_DEN) - 64'd1) / 64'(XFER_DEN);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RC_XFER,
        S_RC_CEIL,
        S_RC_NOM,
        S_DIV,
        S_FRM,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    // Configuration registers
    logic [iaps_pkg::RATE_W-1:0]   r_rate;
    logic [iaps_pkg::FBYTES_W-1:0] r_fbytes;
    logic [iaps_pkg::IVAL_W-1:0]   r_interval;
    logic [iaps_pkg::MODE_W-1:0]   r_mode;
    logic [iaps_pkg::FB_W-1:0]     r_feedback;
    logic [iaps_pkg::EPMAX_W-1:0]  r_epmax;
    logic                          r_explicit;
    logic                          r_dirty;

    // Cached ratios
    logic [iaps_pkg::FB_W-1:0]     r_tgt_num;
    logic [DIV_W-1:0]              r_tgt_den;
    logic [iaps_pkg::CEIL_W-1:0]   r_ceil;
    logic [iaps_pkg::NOMB_W-1:0]   r_nomb;
    logic [XC_W-1:0]               r_xfer;

    // Sequencer and per-transfer state
    t_state                        r_state;
    logic [POS_W-1:0]              r_pos;
    logic [ACC_W-1:0]              r_acc;
    logic [ACC_W-1:0]              r_emit;
    logic [ACC_W-1:0]              r_frames;
    logic [BYTES_W-1:0]            r_bytes;
    logic                          r_cfg_err;
    logic                          r_last;

    // Shared divider
    logic [ACC_W-1:0]              r_quo;
    logic [DIV_W-1:0]              r_rem;
    logic [DIV_W-1:0]              r_dvs;
    logic [CNT_W-1:0]              r_cnt;

    logic [DIV_W:0]                div_shifted;
    logic [DIV_W+1:0]              div_diff;
    logic                          div_take;
    logic [DIV_W-1:0]              n_rem;
    logic [ACC_W-1:0]              n_quo;
    logic                          div_done;

    always_comb begin
        div_shifted = {r_rem, r_quo[ACC_W-1]};
        div_diff    = {1'b0, div_shifted} - {2'b00, r_dvs};
        div_take    = ~div_diff[DIV_W+1];
        n_rem       = div_take ? div_diff[DIV_W-1:0] : div_shifted[DIV_W-1:0];
        n_quo       = {r_quo[ACC_W-2:0], div_take};
        div_done    = (r_cnt == '0);
    end

    // Recompute operands
    logic [iaps_pkg::IPS_W-1:0]    ips;
    logic [iaps_pkg::QMS_W-1:0]    qms;
    logic [PROD_W-1:0]             xfer_prod;
    logic [ACC_W-1:0]              xfer_dividend;
    logic [XMUL_W-1:0]             xfer_mul;
    logic [XQ_W-1:0]               xfer_quo;
    logic                          use_fb;
    logic [ACC_W-1:0]              ceil_dividend;

    always_comb begin
        ips           = iaps_pkg::packets_per_second(r_interval);
        qms           = r_explicit ? iaps_pkg::QMS_W'(iaps_pkg::QMS_EXPLICIT)
                                   : iaps_pkg::QMS_W'(iaps_pkg::QMS_IMPLICIT);
        xfer_prod     = PROD_W'(ips) * PROD_W'(qms);
        xfer_dividend = ACC_W'(xfer_prod) + ACC_W'(XFER_DEN - 1);
        // r_quo holds the rounded-up dividend during S_RC_XFER
        xfer_mul      = XMUL_W'(r_quo[XN_W-1:0]) * XMUL_W'(XFER_RECIP);
        xfer_quo      = xfer_mul[XMUL_W-1:XN_W+XD_L];
        use_fb        = (r_mode == iaps_pkg::MODE_FEEDBACK) && (r_feedback != '0);
        ceil_dividend = ACC_W'(r_tgt_num) + ACC_W'(r_tgt_den) - ACC_W'(1);
    end

    // Item-side operands
    logic [POS_W-1:0]              cur_pos;
    logic                          cur_last;
    logic                          cfg_bad;
    logic [ACC_W-1:0]              acc_base;
    logic [ACC_W-1:0]              emit_base;
    logic [ACC_W-1:0]              acc_new;
    logic [ACC_W-1:0]              frm_next;
    logic [BYTES_W-1:0]            byte_limit;
    logic [XC_W-1:0]               xfer_clamped;

    always_comb begin
        cur_pos = r_pos;
        if (i_restart || (POS_W'(r_pos) >= POS_W'(PACKETS_PER_TRANSFER - 1) + POS_W'(1)
                          && PACKETS_PER_TRANSFER < (1 << POS_W))) begin
            cur_pos = '0;
        end
        if (PACKETS_PER_TRANSFER == 1) begin
            cur_pos = '0;
        end
        cur_last  = (cur_pos == POS_W'(PACKETS_PER_TRANSFER - 1));
        cfg_bad   = (r_rate == '0) || (r_fbytes == '0);
        acc_base  = (cur_pos == '0) ? '0 : r_acc;
        emit_base = (cur_pos == '0) ? '0 : r_emit;
        acc_new   = acc_base + ACC_W'(r_tgt_num);
        // floor difference, at least one frame
        frm_next  = (r_quo > r_emit) ? (r_quo - r_emit) : ACC_W'(1);
        byte_limit = (r_epmax != '0) ? BYTES_W'(r_epmax) : BYTES_W'(r_nomb);
        xfer_clamped = XC_W'(MAX_TRANSFERS);
        if (ACC_W'(xfer_quo) < ACC_W'(iaps_pkg::MIN_TRANSFERS)) begin
            xfer_clamped = XC_W'(iaps_pkg::MIN_TRANSFERS);
        end else if (ACC_W'(xfer_quo) <= ACC_W'(MAX_TRANSFERS)) begin
            xfer_clamped = XC_W'(xfer_quo);
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_dirty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dirty   <= 1'b1;
            r_pos     <= '0;
            r_acc     <= '0;
            r_emit    <= '0;
            r_cnt     <= '0;
            o_valid   <= 1'b0;
            r_rate     <= iaps_pkg::RST_SAMPLE_RATE;
            r_fbytes   <= iaps_pkg::RST_FRAME_BYTES;
            r_interval <= iaps_pkg::RST_EP_INTERVAL;
            r_mode     <= iaps_pkg::RST_ADJUST_MODE;
            r_feedback <= '0;
            r_epmax    <= '0;
            r_explicit <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_dirty) begin
                        r_dirty   <= 1'b0;
                        r_tgt_num <= use_fb ? r_feedback : iaps_pkg::FB_W'(r_rate);
                        r_tgt_den <= use_fb ? DIV_W'(iaps_pkg::FB_ONE) : DIV_W'(ips);
                        r_quo     <= xfer_dividend;
                        r_state   <= S_RC_XFER;
                    end else if (i_valid) begin
                        r_last    <= cur_last;
                        r_pos     <= cur_last ? '0 : cur_pos + POS_W'(1);
                        r_cfg_err <= cfg_bad;
                        if (cfg_bad) begin
                            // accumulator left as it is
                            r_frames <= '0;
                            r_state  <= S_MUL;
                        end else begin
                            r_emit <= emit_base;
                            if (r_mode == iaps_pkg::MODE_NOMINAL) begin
                                r_acc    <= acc_base;
                                r_frames <= ACC_W'(r_ceil);
                                r_state  <= S_MUL;
                            end else begin
                                r_acc   <= acc_new;
                                r_quo   <= acc_new;
                                r_rem   <= '0;
                                r_dvs   <= r_tgt_den;
                                r_cnt   <= CNT_W'(ACC_W - 1);
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_RC_XFER: begin
                    r_xfer  <= xfer_clamped;
                    r_quo   <= ceil_dividend;
                    r_rem   <= '0;
                    r_dvs   <= r_tgt_den;
                    r_cnt   <= CNT_W'(ACC_W - 1);
                    r_state <= S_RC_CEIL;
                end
                S_RC_CEIL: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (div_done) begin
                        r_ceil  <= (n_quo == '0) ? iaps_pkg::CEIL_W'(1)
                                                 : iaps_pkg::CEIL_W'(n_quo);
                        r_state <= S_RC_NOM;
                    end
                end
                S_RC_NOM: begin
                    r_nomb  <= iaps_pkg::NOMB_W'(r_ceil) * iaps_pkg::NOMB_W'(r_fbytes);
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (div_done) begin
                        r_state <= S_FRM;
                    end
                end
                S_FRM: begin
                    r_frames <= frm_next;
                    r_emit   <= r_emit + frm_next;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_bytes <= BYTES_W'(r_frames) * BYTES_W'(r_fbytes);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_cfg_err) begin
                        o_status <= iaps_pkg::STATUS_CFG_ERR;
                    end else if (r_bytes > byte_limit) begin
                        o_status <= iaps_pkg::STATUS_OVER_MAX;
                    end else begin
                        o_status <= iaps_pkg::STATUS_OK;
                    end
                    o_packet_bytes <= (r_bytes > BYTES_W'(iaps_pkg::PBYTES_MAX)) ?
                                      iaps_pkg::PBYTES_MAX : iaps_pkg::PBYTES_W'(r_bytes);
                    o_packet_frames <= (r_frames > ACC_W'(iaps_pkg::PFRAMES_MAX)) ?
                                       iaps_pkg::PFRAMES_MAX : iaps_pkg::PFRAMES_W'(r_frames);
                    o_last_in_transfer <= r_last;
                    o_transfer_count   <= iaps_pkg::XCNT_W'(r_xfer);
                    o_valid            <= 1'b1;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes; a write to a defined index forces the cached ratios to be rebuilt
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    iaps_pkg::CFG_SAMPLE_RATE: begin
                        r_rate  <= i_cfg_data[iaps_pkg::RATE_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    iaps_pkg::CFG_FRAME_BYTES: begin
                        r_fbytes <= i_cfg_data[iaps_pkg::FBYTES_W-1:0];
                        r_dirty  <= 1'b1;
                    end
                    iaps_pkg::CFG_EP_INTERVAL: begin
                        r_interval <= i_cfg_data[iaps_pkg::IVAL_W-1:0];
                        r_dirty    <= 1'b1;
                    end
                    iaps_pkg::CFG_ADJUST_MODE: begin
                        r_mode  <= i_cfg_data[iaps_pkg::MODE_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    iaps_pkg::CFG_FEEDBACK: begin
                        r_feedback <= i_cfg_data[iaps_pkg::FB_W-1:0];
                        r_dirty    <= 1'b1;
                    end
                    iaps_pkg::CFG_EP_MAX_BYTES: begin
                        r_epmax <= i_cfg_data[iaps_pkg::EPMAX_W-1:0];
                        r_dirty <= 1'b1;
                    end
                    iaps_pkg::CFG_EXPLICIT_FB: begin
                        r_explicit <= i_cfg_data[0];
                        r_dirty    <= 1'b1;
                    end
                    default: begin
                        r_dirty <= r_dirty;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* src/iaps_checker.sv */
// Port-level checks for the packet-size sequencer, bound to the top level.
// Depends on iaps_pkg and iso_audio_packet_size_sequencer.
`default_nettype none

module iaps_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [iaps_pkg::PBYTES_W-1:0]    o_packet_bytes,
    input logic [iaps_pkg::PFRAMES_W-1:0]   o_packet_frames,
    input logic [iaps_pkg::STATUS_W-1:0]    o_status
);

    // one item in flight: no new item while a result waits
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("item input open while a result is pending");

    // a result never shows up in the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("result valid directly after item acceptance");

    a_cfg_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == iaps_pkg::STATUS_CFG_ERR) |->
        (o_packet_bytes == '0 && o_packet_frames == '0))
        else $error("invalid configuration gave a non-empty packet");

    a_min_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != iaps_pkg::STATUS_CFG_ERR) |->
        (o_packet_frames != '0 && o_packet_bytes != '0))
        else $error("valid configuration gave an empty packet");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_packet_bytes) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind iso_audio_packet_size_sequencer iaps_checker u_iaps_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for iso_audio_packet_size_sequencer: a directed table of packet slots,
// then random register settings and slot streams, scored against an in-bench predictor
// or a typed row's own result. Depends on iaps_pkg and the top level; reads no files.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iaps_pkg::*;

    localparam int unsigned PKTS_PER_XFER = PACKETS_PER_TRANSFER_DEF;
    localparam int unsigned XFERS_MAX     = MAX_TRANSFERS_DEF;
    localparam int unsigned RANDOM_ITEMS  = 925;
    localparam int unsigned CYCLE_LIMIT   = 800_000;
    localparam int unsigned TAIL_CYCLES   = 200;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned DIR_ROWS      = 25;

    // index past the register list, and the mode code with no meaning of its own
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_SPARE    = 2'd3;

    localparam int unsigned COMMON_RATES [8] = '{8000, 11025, 22050, 32000,
                                                 44100, 48000, 96000, 192000};

    typedef struct packed {
        logic [PBYTES_W-1:0]  bytes;
        logic [PFRAMES_W-1:0] frames;
        logic                 last_slot;
        logic [STATUS_W-1:0]  status;
        logic [XCNT_W-1:0]    xfers;
    } packet_t;

    typedef struct packed {
        logic                  has_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  restart;
        logic                  typed;
        packet_t               res;
    } slot_row_t;

    localparam packet_t NO_RES          = '0;
    localparam packet_t RES_AFTER_RESET = '{bytes: 20'd24, frames: 14'd6, last_slot: 1'b0,
                                            status: STATUS_OK, xfers: 9'd160};
    localparam packet_t RES_BAD_CFG     = '{bytes: 20'd0, frames: 14'd0, last_slot: 1'b0,
                                            status: STATUS_CFG_ERR, xfers: 9'd160};

    slot_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, CFG_SAMPLE_RATE,  32'd0,          1'b0, 1'b1, RES_AFTER_RESET},
        '{1'b0, CFG_SAMPLE_RATE,  32'd0,          1'b1, 1'b0, NO_RES},
        '{1'b1, CFG_SAMPLE_RATE,  32'd44100,      1'b1, 1'b0, NO_RES},
        '{1'b0, CFG_SAMPLE_RATE,  32'd0,          1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_ADJUST_MODE,  32'(MODE_NOMINAL),  1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_ADJUST_MODE,  32'(MODE_SPARE),    1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_ADJUST_MODE,  32'(MODE_FEEDBACK), 1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_FEEDBACK,     32'h0006_0000,  1'b1, 1'b0, NO_RES},
        '{1'b1, CFG_FEEDBACK,     32'hFFFF_FFFF,  1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_FRAME_BYTES,  32'd64,         1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EP_MAX_BYTES, 32'd1,          1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EP_MAX_BYTES, 32'd65535,      1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_FEEDBACK,     32'd1,          1'b1, 1'b0, NO_RES},
        '{1'b0, CFG_SAMPLE_RATE,  32'd0,          1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_SAMPLE_RATE,  32'd0,          1'b1, 1'b1, RES_BAD_CFG},
        '{1'b1, CFG_SAMPLE_RATE,  32'hF_FFFF,     1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_ADJUST_MODE,  32'(MODE_CONSERVATIVE), 1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_FRAME_BYTES,  32'd0,          1'b1, 1'b1, RES_BAD_CFG},
        '{1'b1, CFG_FRAME_BYTES,  32'd1,          1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EP_INTERVAL,  32'd0,          1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EP_INTERVAL,  32'd255,        1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EXPLICIT_FB,  32'd1,          1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EP_INTERVAL,  32'd13,         1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_IDX_SPARE,    32'hFFFF_FFFF,  1'b0, 1'b0, NO_RES},
        '{1'b1, CFG_EP_MAX_BYTES, 32'd0,          1'b0, 1'b0, NO_RES}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic                  i_restart  = 1'b0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [PBYTES_W-1:0]   o_packet_bytes;
    logic [PFRAMES_W-1:0]  o_packet_frames;
    logic                  o_last_in_transfer;
    logic [STATUS_W-1:0]   o_status;
    logic [XCNT_W-1:0]     o_transfer_count;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    iso_audio_packet_size_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_restart          (i_restart),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_packet_bytes     (o_packet_bytes),
        .o_packet_frames    (o_packet_frames),
        .o_last_in_transfer (o_last_in_transfer),
        .o_status           (o_status),
        .o_transfer_count   (o_transfer_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    // register mirror and per-transfer state of the predictor
    logic [RATE_W-1:0]   m_rate;
    logic [FBYTES_W-1:0] m_fbytes;
    logic [IVAL_W-1:0]   m_ival;
    logic [MODE_W-1:0]   m_mode;
    logic [FB_W-1:0]     m_fb;
    logic [EPMAX_W-1:0]  m_epmax;
    logic                m_explicit;
    longint unsigned     acc_sum, frames_out, ratio_num, ratio_den, nom_bytes;
    int unsigned         slot_pos;
    logic [XCNT_W-1:0]   pool_xfers;

    packet_t     packets_due [$];
    packet_t     typed_res;
    bit          typed_armed;
    bit          in_take, out_take;
    bit          hold_req;
    int unsigned tx_idle_pct, rx_idle_pct;
    int unsigned cycle_count, fail_count, items_sent, results_seen, cfg_writes;
    int unsigned n_ok, n_bad_cfg, n_over, n_last;

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned slots_per_second(input logic [IVAL_W-1:0] iv);
        longint unsigned shift;
        if (iv <= 1) return IPS_HS;
        if (iv > IVAL_FS_ABOVE) return IPS_FS;
        shift = iv - 1;
        if (shift > IVAL_SHIFT_MAX) shift = IVAL_SHIFT_MAX;
        return ((IPS_HS >> shift) == 0) ? 1 : (IPS_HS >> shift);
    endfunction

    function automatic void refresh_ratio();
        longint unsigned ips, qms, per_xfer, pool, whole;
        ips      = slots_per_second(m_ival);
        qms      = m_explicit ? QMS_EXPLICIT : QMS_IMPLICIT;
        per_xfer = MS_PER_S * PKTS_PER_XFER;
        pool     = (ips * qms + per_xfer - 1) / per_xfer;
        if (pool < MIN_TRANSFERS) pool = MIN_TRANSFERS;
        if (pool > XFERS_MAX) pool = XFERS_MAX;
        pool_xfers = XCNT_W'(pool);
        if (m_mode == MODE_FEEDBACK && m_fb != 0) begin
            ratio_num = m_fb;
            ratio_den = FB_ONE;
        end else begin
            ratio_num = m_rate;
            ratio_den = ips;
        end
        whole = (ratio_num + ratio_den - 1) / ratio_den;
        if (whole == 0) whole = 1;
        nom_bytes = whole * m_fbytes;
    endfunction

    function automatic void reset_mirror();
        m_rate     = RST_SAMPLE_RATE;
        m_fbytes   = RST_FRAME_BYTES;
        m_ival     = RST_EP_INTERVAL;
        m_mode     = RST_ADJUST_MODE;
        m_fb       = '0;
        m_epmax    = '0;
        m_explicit = 1'b0;
        acc_sum    = 0;
        frames_out = 0;
        slot_pos   = 0;
        refresh_ratio();
    endfunction

    function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SAMPLE_RATE:  m_rate     = data[RATE_W-1:0];
            CFG_FRAME_BYTES:  m_fbytes   = data[FBYTES_W-1:0];
            CFG_EP_INTERVAL:  m_ival     = data[IVAL_W-1:0];
            CFG_ADJUST_MODE:  m_mode     = data[MODE_W-1:0];
            CFG_FEEDBACK:     m_fb       = data[FB_W-1:0];
            CFG_EP_MAX_BYTES: m_epmax    = data[EPMAX_W-1:0];
            CFG_EXPLICIT_FB:  m_explicit = data[0];
            default:          return;
        endcase
        refresh_ratio();
    endfunction

    function automatic packet_t predict_packet(input logic restart);
        packet_t         p;
        longint unsigned n_frames, n_bytes, limit, whole;
        p        = '0;
        n_frames = 0;
        n_bytes  = 0;
        if (restart || slot_pos >= PKTS_PER_XFER) slot_pos = 0;
        p.last_slot = (slot_pos == PKTS_PER_XFER - 1);
        p.status    = STATUS_OK;
        if (m_rate == 0 || m_fbytes == 0) begin
            // slot still advances, accumulator left alone
            p.status = STATUS_CFG_ERR;
        end else begin
            if (slot_pos == 0) begin
                acc_sum    = 0;
                frames_out = 0;
            end
            if (m_mode == MODE_NOMINAL) begin
                n_frames = (ratio_num + ratio_den - 1) / ratio_den;
                if (n_frames == 0) n_frames = 1;
            end else begin
                acc_sum  += ratio_num;
                whole    = acc_sum / ratio_den;
                n_frames = (whole > frames_out) ? whole - frames_out : 1;
                frames_out += n_frames;
            end
            n_bytes = n_frames * m_fbytes;
            limit   = (m_epmax != 0) ? m_epmax : nom_bytes;
            if (n_bytes > limit) p.status = STATUS_OVER_MAX;
        end
        slot_pos = p.last_slot ? 0 : slot_pos + 1;
        p.bytes  = (n_bytes > PBYTES_MAX) ? PBYTES_MAX : PBYTES_W'(n_bytes);
        p.frames = (n_frames > PFRAMES_MAX) ? PFRAMES_MAX : PFRAMES_W'(n_frames);
        p.xfers  = pool_xfers;
        return p;
    endfunction

    // Handshakes are judged at the falling edge, where every signal is settled; the
    // acceptance itself happens at the following rising edge.
    always @(negedge i_clk) begin
        packet_t want, got;
        in_take  = i_rst_n && i_valid && (o_stall === 1'b0);
        out_take = i_rst_n && (o_valid === 1'b1) && !i_stall;
        if (in_take) begin
            want = predict_packet(i_restart);
            if (typed_armed) begin
                want        = typed_res;
                typed_armed = 1'b0;
            end
            packets_due = {packets_due, want};
        end
        if (out_take) begin
            got = '{o_packet_bytes, o_packet_frames, o_last_in_transfer, o_status,
                    o_transfer_count};
            results_seen++;
            if (got.status == STATUS_OK) n_ok++;
            if (got.status == STATUS_CFG_ERR) n_bad_cfg++;
            if (got.status == STATUS_OVER_MAX) n_over++;
            if (got.last_slot === 1'b1) n_last++;
            if (packets_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("cycle %0d: result with nothing due: bytes %0d frames %0d",
                             cycle_count, got.bytes, got.frames);
            end else begin
                want = packets_due.pop_front();
                if (got.bytes !== want.bytes || got.frames !== want.frames ||
                    got.last_slot !== want.last_slot || got.status !== want.status ||
                    got.xfers !== want.xfers) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $write("cycle %0d mismatch (exp/act): bytes %0d/%0d frames %0d/%0d",
                               cycle_count, want.bytes, got.bytes, want.frames, got.frames);
                        $display(" last %0b/%0b status %0d/%0d xfers %0d/%0d",
                                 want.last_slot, got.last_slot, want.status, got.status,
                                 want.xfers, got.xfers);
                    end
                end
            end
        end
    end

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 packets_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // offer one packet slot and hold it until the block takes it
    task automatic offer_slot(input logic restart);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!in_take);
        items_sent++;
    endtask

    // write enable is left high; the caller drops it after the last write of a group
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        mirror_write(idx, data);
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_settings();
        logic [RATE_W-1:0]   rate;
        logic [FBYTES_W-1:0] fbytes;
        logic [IVAL_W-1:0]   ival;
        longint signed       near;
        int unsigned         pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) rate = '0;
        else if (pick < 16) rate = RATE_W'($urandom_range(0, 20'hF_FFFF));
        else rate = RATE_W'(COMMON_RATES[$urandom_range(0, 7)]);
        pick = $urandom_range(0, 99);
        if (pick < 4) fbytes = '0;
        else if (pick < 12) fbytes = 7'd64;
        else fbytes = FBYTES_W'($urandom_range(1, 64));
        ival = ($urandom_range(0, 99) < 70) ? IVAL_W'($urandom_range(1, 4))
                                            : IVAL_W'($urandom_range(0, 255));
        cfg_write(CFG_SAMPLE_RATE, CFG_DATA_W'(rate));
        cfg_write(CFG_FRAME_BYTES, CFG_DATA_W'(fbytes));
        cfg_write(CFG_EP_INTERVAL, CFG_DATA_W'(ival));
        cfg_write(CFG_EXPLICIT_FB, CFG_DATA_W'($urandom_range(0, 1)));
        cfg_write(CFG_ADJUST_MODE, CFG_DATA_W'($urandom_range(0, 3)));
        // feedback zero, random, or close to the nominal ratio as a real sink would report it
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            near = 0;
        end else if (pick < 55) begin
            near = (longint'(rate) * FB_ONE) / longint'(slots_per_second(ival));
            near = near + longint'($urandom_range(0, 4000)) - 2000;
            if (near < 0) near = 0;
        end else begin
            near = longint'($urandom());
        end
        cfg_write(CFG_FEEDBACK, CFG_DATA_W'(near));
        // endpoint max zero, random or near nominal so the over-size check trips both ways
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            near = 0;
        end else if (pick < 80) begin
            near = longint'(nom_bytes) + longint'($urandom_range(0, 8)) - 4;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
        end else begin
            near = longint'($urandom_range(0, 65535));
        end
        cfg_write(CFG_EP_MAX_BYTES, CFG_DATA_W'(near));
    endtask

    initial begin : stimulus
        int unsigned phase, rand_sent, restart_odds, chunk_len, phase_goal;
        bit          held;
        rand_sent   = 0;
        held        = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        reset_mirror();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].has_cfg) begin
                drain();
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
                i_cfg_we <= 1'b0;
            end
            typed_res   = dir_rows[r].res;
            typed_armed = dir_rows[r].typed;
            offer_slot(dir_rows[r].restart);
        end

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 55 : 0;
            rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 22 : 0;
            phase_goal  = (phase + 1) * RANDOM_ITEMS / 3;
            while (rand_sent < phase_goal) begin
                drain();
                pick_settings();
                i_cfg_we <= 1'b0;
                // mostly whole transfers; now and then a burst of restarts
                restart_odds = ($urandom_range(0, 4) == 0) ? 3 : 48;
                chunk_len    = $urandom_range(12, 64);
                if (chunk_len > phase_goal - rand_sent) chunk_len = phase_goal - rand_sent;
                if (phase == 2 && !held) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                repeat (chunk_len) begin
                    offer_slot($urandom_range(1, restart_odds) == 1);
                    rand_sent++;
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d packet slots (%0d from the table), %0d results, %0d register writes",
                 items_sent, DIR_ROWS, results_seen, cfg_writes);
        $display("status ok/config error/over max: %0d/%0d/%0d, %0d transfer ends, %0d failures",
                 n_ok, n_bad_cfg, n_over, n_last, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
src/iaps_pkg.sv
src/iso_audio_packet_size_sequencer.sv
src/iaps_checker.sv
sim/testbench.sv
